// File: rtl/core/srgbds_pkg.sv
// ----------------------------------------------------------------------------
// srgbds_pkg
// Shared types, constants and table builders of the sRGB box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package srgbds_pkg;

   localparam int MAX_WIDTH_DEF   = 2048;
   localparam int MAX_LEVELS_DEF  = 11;
   localparam int LINEAR_BITS_DEF = 16;

   localparam int WIDTH_REG_W  = 12;
   localparam int HALV_W       = 4;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CODE_BITS    = 8;
   localparam int TAB_DEPTH    = 256;
   localparam int LIN_W_MAX    = 24;
   localparam int THR_W_MAX    = LIN_W_MAX + 2;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   // denominators of the linear and the power segment of the decode curve
   localparam logic [63:0] DEC_LOW_DEN  = 64'd510 * 64'd1292;
   localparam logic [63:0] DEC_HIGH_DEN = 64'd1055 * 64'd510;

   typedef enum logic {
      REG_SOURCE_WIDTH  = 1'b0,
      REG_HALVING_COUNT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       last_of_frame;
      logic       bad_config;
   } rsp_payload_type;

   // pixel as it travels along the chain of level cells (index 0 red, 1 green, 2 blue)
   typedef struct packed {
      logic                 valid;
      logic                 done;
      logic                 last;
      logic                 bad;
      logic [2:0][7:0]      rgb;
   } item_type;

   typedef logic [LIN_W_MAX-1:0] lin_tab_type [TAB_DEPTH];
   typedef logic [THR_W_MAX-1:0] thr_tab_type [TAB_DEPTH];

   function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   // Q30 of the sRGB decode curve at n/510
   function automatic logic [63:0] decode_q30(logic [63:0] n);
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] p;
      if (n * 64'd100000 <= 64'd4045 * 64'd510)
         return (n * Q30_ONE * 64'd100) / DEC_LOW_DEN;
      t = ((n * 64'd1000 + 64'd55 * 64'd510) << 30) / DEC_HIGH_DEN;
      if (t > Q30_ONE)
         t = Q30_ONE;
      t2 = q30_mul(t, t);
      lo = 64'd0;
      hi = Q30_ONE;
      for (int it = 0; it < 40; it++) begin
         if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            p = q30_mul(q30_mul(q30_mul(q30_mul(mid, mid), mid), mid), mid);
            if (p <= t2)
               lo = mid;
            else
               hi = mid - 64'd1;
         end
      end
      return q30_mul(t2, lo);
   endfunction

   function automatic lin_tab_type build_lin(int lb);
      lin_tab_type tab;
      logic [63:0] fs;
      logic [63:0] v;
      fs = (64'd1 << lb) - 64'd1;
      for (int i = 0; i < TAB_DEPTH; i++) begin
         v = (decode_q30(64'(2 * i)) * fs + (Q30_ONE >> 1)) >> 30;
         tab[i] = v[LIN_W_MAX-1:0];
      end
      return tab;
   endfunction

   // smallest four-pixel sum that reaches code v
   function automatic thr_tab_type build_thr(int lb);
      thr_tab_type tab;
      logic [63:0] fs;
      logic [63:0] v;
      fs = (64'd1 << lb) - 64'd1;
      tab[0] = '0;
      for (int i = 1; i < TAB_DEPTH; i++) begin
         v = (64'd4 * fs * decode_q30(64'(2 * i - 1)) + Q30_ONE - 64'd1) >> 30;
         tab[i] = v[THR_W_MAX-1:0];
      end
      return tab;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/srgbds_stream_if.sv
// ----------------------------------------------------------------------------
// srgbds_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface srgbds_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/core/srgbds_cell.sv
// ----------------------------------------------------------------------------
// srgbds_cell
// One halving level: linearise, pair, row buffer, sum, sRGB threshold search.
// ----------------------------------------------------------------------------
`default_nettype none

module srgbds_cell
   import srgbds_pkg::*;
#(
   parameter int K           = 0,
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int LINEAR_BITS = LINEAR_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        clear,
   input  logic [$clog2(MAX_WIDTH):0]  width,
   input  logic [HALV_W-1:0]           halvings,
   input  item_type                    up_item,
   output item_type                    dn_item
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WB  = CW + 1;
   localparam int LB  = LINEAR_BITS;
   localparam int PB  = LB + 1;
   localparam int SB  = LB + 2;
   localparam int MD  = ((MAX_WIDTH >> (K + 1)) > 0) ? (MAX_WIDTH >> (K + 1)) : 1;
   localparam int AW  = ($clog2(MD) > 0) ? $clog2(MD) : 1;
   localparam lin_tab_type LIN = build_lin(LB);
   localparam thr_tab_type THR = build_thr(LB);

   typedef struct packed {
      item_type              it;
      logic                  pv;
      logic                  row_odd;
      logic [AW-1:0]         idx;
      logic [2:0][PB-1:0]    pair;
   } st_a_type;

   typedef struct packed {
      item_type              it;
      logic                  ev;
      logic [2:0][PB-1:0]    pair;
   } st_b_type;

   typedef struct packed {
      item_type              it;
      logic                  ev;
      logic [2:0][SB-1:0]    sum;
      logic [2:0][7:0]       code;
   } st_e_type;

   logic [CW-1:0]         col_ff, col_in, row_ff, row_in;
   logic [2:0][LB-1:0]    pend_ff, pend_in;
   logic [2:0][LB-1:0]    lin;
   logic [WB-1:0]         wk, col_nx, row_nx;
   logic                  active, final_lvl;
   st_a_type              a_ff, a_in;
   st_b_type              b_ff, b_in;
   logic [2:0][PB-1:0]    rd_ff;
   st_e_type              c_ff, c_in;
   st_e_type              enc_ff  [CODE_BITS];
   st_e_type              enc_in  [CODE_BITS];
   st_e_type              enc_src [CODE_BITS];
   logic [3*PB-1:0]       mem     [MD];
   logic [7:0]            trial;

   assign wk        = WB'(width >> K);
   assign col_nx    = {1'b0, col_ff} + WB'(1);
   assign row_nx    = {1'b0, row_ff} + WB'(1);
   assign active    = up_item.valid & ~up_item.done;
   assign final_lvl = (halvings == HALV_W'(K));

   // count position, hand on finished pixels, pair up the rest
   always_comb begin
      a_in    = '0;
      a_in.it = up_item;
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      for (int ch = 0; ch < 3; ch++)
         lin[ch] = LIN[up_item.rgb[ch]][LB-1:0];
      if (active) begin
         if (col_nx >= wk) begin
            col_in = '0;
            row_in = (row_nx >= wk) ? '0 : row_nx[CW-1:0];
         end else begin
            col_in = col_nx[CW-1:0];
         end
         if (final_lvl) begin
            a_in.it.done = 1'b1;
            a_in.it.last = (col_nx == wk) && (row_nx == wk);
         end else begin
            a_in.it.valid = 1'b0;
            if (col_ff[0]) begin
               a_in.pv      = 1'b1;
               a_in.row_odd = row_ff[0];
               a_in.idx     = AW'(col_ff >> 1);
               for (int ch = 0; ch < 3; ch++)
                  a_in.pair[ch] = PB'(pend_ff[ch]) + PB'(lin[ch]);
            end else begin
               pend_in = lin;
            end
         end
      end
      if (clear) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (adv || clear) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv)
         pend_ff <= pend_in;
   end

   // upper row: store the pair sum; lower row: fetch it back
   always_ff @(posedge clock) begin
      if (adv) begin
         if (a_ff.pv && !a_ff.row_odd)
            mem[a_ff.idx] <= a_ff.pair;
         rd_ff <= mem[a_ff.idx];
      end
   end

   always_comb begin
      b_in.it   = a_ff.it;
      b_in.ev   = a_ff.pv & a_ff.row_odd;
      b_in.pair = a_ff.pair;
   end

   always_comb begin
      c_in.it   = b_ff.it;
      c_in.ev   = b_ff.ev;
      c_in.code = '0;
      for (int ch = 0; ch < 3; ch++)
         c_in.sum[ch] = SB'(rd_ff[ch]) + SB'(b_ff.pair[ch]);
   end

   // one code bit per stage, most significant first
   always_comb begin
      trial = '0;
      for (int j = 0; j < CODE_BITS; j++) begin
         enc_src[j] = (j == 0) ? c_ff : enc_ff[(j > 0) ? j - 1 : 0];
         enc_in[j]  = enc_src[j];
         for (int ch = 0; ch < 3; ch++) begin
            trial = enc_src[j].code[ch] | 8'(8'd1 << (CODE_BITS - 1 - j));
            if (enc_src[j].sum[ch] >= THR[trial][SB-1:0])
               enc_in[j].code[ch] = trial;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
         for (int j = 0; j < CODE_BITS; j++)
            enc_ff[j] <= '0;
      end else if (adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         for (int j = 0; j < CODE_BITS; j++)
            enc_ff[j] <= enc_in[j];
      end
   end

   always_comb begin
      dn_item = enc_ff[CODE_BITS-1].it;
      if (enc_ff[CODE_BITS-1].ev) begin
         dn_item.valid = 1'b1;
         dn_item.done  = 1'b0;
         dn_item.last  = 1'b0;
         dn_item.bad   = 1'b0;
         dn_item.rgb   = enc_ff[CODE_BITS-1].code;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/srgb_linear_box_downsample.sv
// ----------------------------------------------------------------------------
// srgb_linear_box_downsample
// Gamma-correct 2x2 box downsampler for a square sRGB raster stream.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock unless the chain stalls, and returns one
// pixel per clock at most. The datapath is a row of MAX_LEVELS+1 level cells;
// every pixel walks through all of them, through each cell's pair, sum and
// code-bit registers, then the output register. Each cell keeps its own
// column/row counters, a left-pixel register and a row buffer of pair sums;
// it hands on finished pixels and the 2x2 averages it produces. A stall only
// occurs when the output register is full, not taken, and a result is about
// to arrive. The row buffers need no clearing pass. Any register write
// restarts the frame. With an unusable setting of width and halving count
// every transfer gives one result flagged bad_config.
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_linear_box_downsample
   import srgbds_pkg::*;
#(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
   parameter int LINEAR_BITS = LINEAR_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   srgbds_stream_if.sink           req_if,
   srgbds_stream_if.source         rsp_if,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   localparam int NC = MAX_LEVELS + 1;
   localparam int WB = $clog2(MAX_WIDTH) + 1;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HALV_W-1:0]       halv_ff;
   reg_index_type           reg_sel;
   logic                    csr_wr;
   logic                    bad;
   logic [15:0]             mask;
   logic                    adv;
   item_type                link [NC+1];
   item_type                head;
   item_type                rsp_ff;
   logic                    rsp_valid_ff;

   // ---- configuration port ----
   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[2]);
   assign csr_wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_REG_W'(512);
         halv_ff  <= HALV_W'(1);
      end else if (csr_wr) begin
         case (reg_sel)
            REG_SOURCE_WIDTH:  width_ff <= pwdata[WIDTH_REG_W-1:0];
            REG_HALVING_COUNT: halv_ff  <= pwdata[HALV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SOURCE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_HALVING_COUNT: prdata = CSR_DATA_W'(halv_ff);
         default:           prdata = '0;
      endcase
   end

   // ---- usable configuration check ----
   assign mask = (16'd1 << halv_ff) - 16'd1;
   assign bad  = (width_ff == '0)
              || (32'(width_ff) > MAX_WIDTH)
              || (32'(halv_ff) > MAX_LEVELS)
              || ((16'(width_ff) & mask) != 16'd0);

   // advance unless a result would land on a full, stalled output register
   assign adv          = ~rsp_valid_ff | rsp_if.ready | ~link[NC].valid;
   assign req_if.ready = adv;

   // bad transfers enter already finished, so no counter moves
   always_comb begin
      head.valid  = req_if.valid & adv;
      head.done   = bad;
      head.bad    = bad;
      head.last   = 1'b0;
      head.rgb[0] = bad ? 8'd0 : req_if.payload.red_in;
      head.rgb[1] = bad ? 8'd0 : req_if.payload.green_in;
      head.rgb[2] = bad ? 8'd0 : req_if.payload.blue_in;
   end

   assign link[0] = head;

   for (genvar k = 0; k < NC; k++) begin : g_cell
      srgbds_cell #(
         .K           (k),
         .MAX_WIDTH   (MAX_WIDTH),
         .LINEAR_BITS (LINEAR_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .clear    (csr_wr),
         .width    (WB'(width_ff)),
         .halvings (halv_ff),
         .up_item  (link[k]),
         .dn_item  (link[k+1])
      );
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && link[NC].valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && link[NC].valid)
         rsp_ff <= link[NC];
   end

   assign rsp_if.valid                 = rsp_valid_ff;
   assign rsp_if.payload.red_out       = rsp_ff.rgb[0];
   assign rsp_if.payload.green_out     = rsp_ff.rgb[1];
   assign rsp_if.payload.blue_out      = rsp_ff.rgb[2];
   assign rsp_if.payload.last_of_frame = rsp_ff.last;
   assign rsp_if.payload.bad_config    = rsp_ff.bad;

   // ---- checks ----
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bad |-> rsp_ff.rgb == '0 && !rsp_ff.last)
      else $error("bad_config result carries colour or frame end");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !adv |-> rsp_valid_ff && !rsp_if.ready && link[NC].valid)
      else $error("chain stalled without a blocked result");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> rsp_valid_ff)
      else $error("pending result dropped during stall");

endmodule

`default_nettype wire

// File: tb/tb_srgb_linear_box_downsample.sv
// ----------------------------------------------------------------------------
// tb_srgb_linear_box_downsample
// Self-checking testbench of the gamma-correct 2x2 box downsampler.
// ----------------------------------------------------------------------------
// Drives raster pixel streams under a range of width/halving settings through
// the APB port, predicts every output pixel with an independent fixed-point
// model of the decode table, pair/row accumulation and threshold encoding, and
// compares each result transfer field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_srgb_linear_box_downsample;
   import srgbds_pkg::*;

   localparam int  MAXW       = 2048;
   localparam int  MAXLEV     = 11;
   localparam int  NLEV       = MAXLEV + 1;
   localparam logic [63:0] FS = 64'd65535;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam int  LATENCY    = 300;      // comfortably beyond the pipeline
   localparam int  CYCLE_LIMIT = 2000000;
   localparam int  RANDOM_ITEMS = 715;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   srgbds_stream_if #(.payload_type(req_payload_type)) req_ch ();
   srgbds_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   srgb_linear_box_downsample dut (
      .clock(clock), .reset(reset),
      .req_if(req_ch.sink), .rsp_if(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // ---------------------------------------------------------------- model state
   logic [63:0] lin_of_code [256];
   logic [63:0] code_threshold [256];
   logic [11:0] width_reg;
   logic [3:0]  halvings_reg;
   logic [17:0] row_pair_sums [MAXW][3];
   logic [17:0] left_pixel [NLEV][3];
   int unsigned col_count [NLEV];
   int unsigned row_count [NLEV];

   rsp_payload_type expected_pixels [$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  hold_request = 0;   // long receiver hold-off, taken up by the ready process
   bit  calm = 0;           // no idling on either side while set

   // ---------------------------------------------------------------- clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   // sRGB decode curve at num/den in Q30; x^2.4 as x^2 times fifth root of x^2
   function automatic logic [63:0] srgb_decode_q30(logic [63:0] num, logic [63:0] den);
      logic [63:0] base, sq, lo, hi, mid, pw;
      if (num * 64'd100000 <= 64'd4045 * den)
         return (num * ONE_Q30 * 64'd100) / (den * 64'd1292);
      base = ((num * 64'd1000 + 64'd55 * den) << 30) / (64'd1055 * den);
      if (base > ONE_Q30) base = ONE_Q30;
      sq = qmul(base, base);
      lo = 0;
      hi = ONE_Q30;
      while (lo < hi) begin
         mid = (lo + hi + 64'd1) >> 1;
         pw = qmul(qmul(qmul(qmul(mid, mid), mid), mid), mid);
         if (pw <= sq) lo = mid;
         else hi = mid - 64'd1;
      end
      return qmul(sq, lo);
   endfunction

   function automatic logic [7:0] encode_block(logic [63:0] sum4);
      int cnt;
      cnt = 0;
      for (int v = 1; v < 256; v++)
         if ((sum4 << 30) >= 64'd4 * FS * code_threshold[v]) cnt++;
      return 8'(cnt);
   endfunction

   function automatic void clear_counts();
      for (int k = 0; k < NLEV; k++) begin
         col_count[k] = 0;
         row_count[k] = 0;
      end
   endfunction

   // Advance the model by one accepted source pixel; queue the output pixel if any.
   function automatic void predict_pixel(req_payload_type px_in);
      int unsigned w, h, wk, col, row, idx;
      logic [7:0]  px [3];
      logic [17:0] lin [3];
      logic [17:0] pair [3];
      rsp_payload_type r;
      w = width_reg;
      h = halvings_reg;
      if (w == 0 || w > MAXW || h > MAXLEV || (w & ((1 << h) - 1)) != 0) begin
         r = '0;
         r.bad_config = 1'b1;
         expected_pixels.push_back(r);
         return;
      end
      px[0] = px_in.red_in;
      px[1] = px_in.green_in;
      px[2] = px_in.blue_in;
      for (int k = 0; k <= h; k++) begin
         wk  = w >> k;
         col = col_count[k];
         row = row_count[k];
         if (col + 1 >= wk) begin
            col_count[k] = 0;
            row_count[k] = (row + 1 >= wk) ? 0 : row + 1;
         end else begin
            col_count[k] = col + 1;
         end
         if (k == h) begin
            r.red_out       = px[0];
            r.green_out     = px[1];
            r.blue_out      = px[2];
            r.last_of_frame = (col == wk - 1 && row == wk - 1);
            r.bad_config    = 1'b0;
            expected_pixels.push_back(r);
            return;
         end
         for (int c = 0; c < 3; c++) lin[c] = 18'(lin_of_code[px[c]]);
         // hold the left pixel of a pair
         if ((col & 1) == 0) begin
            for (int c = 0; c < 3; c++) left_pixel[k][c] = lin[c];
            return;
         end
         for (int c = 0; c < 3; c++) pair[c] = left_pixel[k][c] + lin[c];
         idx = (MAXW - (MAXW >> k) + (col >> 1)) % MAXW;
         // upper row of the block: store the pair sum
         if ((row & 1) == 0) begin
            for (int c = 0; c < 3; c++) row_pair_sums[idx][c] = pair[c];
            return;
         end
         for (int c = 0; c < 3; c++)
            px[c] = encode_block(64'(row_pair_sums[idx][c]) + 64'(pair[c]));
      end
   endfunction

   // ---------------------------------------------------------------- result check
   // Sample at the falling edge: inputs only move at rising edges, so this is
   // the value that the next rising edge sees.
   always @(negedge clock) begin
      rsp_payload_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (expected_pixels.size() == 0) begin
            $error("unexpected result transfer %h", got);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (got.red_out !== want.red_out) begin
               $error("red_out expected %0d actual %0d", want.red_out, got.red_out);
               error_count++;
            end
            if (got.green_out !== want.green_out) begin
               $error("green_out expected %0d actual %0d", want.green_out, got.green_out);
               error_count++;
            end
            if (got.blue_out !== want.blue_out) begin
               $error("blue_out expected %0d actual %0d", want.blue_out, got.blue_out);
               error_count++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
               $error("last_of_frame expected %0d actual %0d",
                      want.last_of_frame, got.last_of_frame);
               error_count++;
            end
            if (got.bad_config !== want.bad_config) begin
               $error("bad_config expected %0d actual %0d", want.bad_config, got.bad_config);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   function automatic int gap_length();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
   endfunction

   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_request > 0) begin
         // long hold-off so the pipeline fills and back-pressures the input
         stall_left    = hold_request;
         hold_request  = 0;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left    = gap_length() - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- sender
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_payload_type px;
      bit taken;
      int gap;
      px.red_in   = r;
      px.green_in = g;
      px.blue_in  = b;
      gap = (!calm && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= px;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ch.ready;
         if (taken) predict_pixel(px);
         @(posedge clock);
      end
   endtask

   task automatic send_random_pixel();
      logic [7:0] c [3];
      for (int i = 0; i < 3; i++)
         c[i] = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
                                            : 8'($urandom);
      send_pixel(c[0], c[1], c[2]);
   endtask

   // Drop valid and wait until every expected result has left, plus pipeline slack.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // APB write: setup phase then access phase; the register takes the data at
   // the edge that ends the access phase. The bus then idles before the task returns.
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_SOURCE_WIDTH) width_reg = value[11:0];
      else halvings_reg = value[3:0];
      clear_counts();
      @(posedge clock);
   endtask

   task automatic configure(int w, int h);
      drain();
      csr_write(REG_SOURCE_WIDTH, 32'(w));
      csr_write(REG_HALVING_COUNT, 32'(h));
   endtask

   task automatic send_frame(int w);
      repeat (w * w) send_random_pixel();
   endtask

   // ---------------------------------------------------------------- tests
   int sent_random = 0;

   task automatic test_reset_setting();
      // reset leaves width 512, one halving: a few pixels of row 0, no output
      repeat (6) send_random_pixel();
   endtask

   task automatic test_passthrough();
      configure(1, 0);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hff, 8'hff, 8'hff);
      send_pixel(8'hff, 8'h00, 8'h80);
   endtask

   task automatic test_directed_blocks();
      configure(2, 1);
      repeat (4) send_pixel(8'hff, 8'hff, 8'hff);
      repeat (4) send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hff, 8'h00, 8'h01);
      send_pixel(8'h00, 8'hff, 8'hfe);
      send_pixel(8'h00, 8'h00, 8'h7f);
      send_pixel(8'hff, 8'hff, 8'h80);
      configure(4, 2);
      send_frame(4);
   endtask

   task automatic test_bad_config();
      configure(0, 0);
      send_random_pixel();
      configure(3, 1);
      send_random_pixel();
      configure(4, 12);
      send_random_pixel();
      configure(4, 15);
      send_random_pixel();
      configure(4095, 0);
      send_random_pixel();
      configure(2049, 0);
      send_random_pixel();
      // bits above each register's width are ignored: width 16, halvings 2
      drain();
      csr_write(REG_SOURCE_WIDTH, 32'hffff_f010);
      csr_write(REG_HALVING_COUNT, 32'hffff_fff2);
      send_frame(16);
   endtask

   task automatic test_widest();
      configure(2048, 0);
      repeat (8) send_random_pixel();
      configure(2048, 11);
      repeat (8) send_random_pixel();
   endtask

   task automatic test_back_pressure();
      configure(16, 0);
      calm = 1;
      @(posedge clock);
      hold_request = 600;
      repeat (256) send_random_pixel();
      calm = 0;
      // sender pauses until every result is out, then carries on mid-frame
      configure(8, 1);
      repeat (40) send_random_pixel();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (24) send_random_pixel();
   endtask

   task automatic test_random_frames();
      int widths [8] = '{4, 8, 8, 2, 6, 16, 1, 12};
      int halvs  [8] = '{2, 1, 3, 1, 1, 2, 0, 2};
      int pick, n;
      while (sent_random < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 7);
         if ($urandom_range(0, 9) == 0) begin
            // noise: unusable setting
            configure(widths[pick] + 1 - (widths[pick] & 1), $urandom_range(1, 3));
            n = $urandom_range(1, 5);
         end else begin
            configure(widths[pick], halvs[pick]);
            n = widths[pick] * widths[pick] * $urandom_range(1, 2);
            // broken frame now and then: cut short, the next write restarts it
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
         end
         if (n > RANDOM_ITEMS - sent_random) n = RANDOM_ITEMS - sent_random;
         calm = ($urandom_range(0, 4) == 0);
         repeat (n) send_random_pixel();
         calm = 0;
         sent_random += n;
      end
   endtask

   // ---------------------------------------------------------------- main
   initial begin
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      for (int i = 0; i < 256; i++) begin
         lin_of_code[i] = (srgb_decode_q30(64'(i), 64'd255) * FS + (ONE_Q30 >> 1)) >> 30;
         code_threshold[i] = (i == 0) ? 64'd0 : srgb_decode_q30(64'(2 * i - 1), 64'd510);
      end
      width_reg    = 12'd512;
      halvings_reg = 4'd1;
      clear_counts();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_setting();
      test_passthrough();
      test_directed_blocks();
      test_bad_config();
      test_widest();
      test_back_pressure();
      test_random_frames();
      drain();

      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
